/* design/bba_pkg.sv */
// bba_pkg: shared types and constants for the bitmap block allocator
// no dependencies
`default_nettype none
package bba_pkg;
    localparam int MAX_BLOCKS_DEF = 4096;
    localparam int WORD_BITS_DEF  = 32;
    localparam int CFG_W          = 13;
    localparam int BLK_W          = 12;
    localparam int ST_W           = 2;

    localparam logic [ST_W-1:0] ST_OK           = 2'd0;
    localparam logic [ST_W-1:0] ST_NO_SPACE     = 2'd1;
    localparam logic [ST_W-1:0] ST_ALREADY_FREE = 2'd2;
    localparam logic [ST_W-1:0] ST_OUT_OF_RANGE = 2'd3;

    localparam logic CMD_ALLOC = 1'b0;
    localparam logic CMD_FREE  = 1'b1;

    localparam logic [0:0] REG_BLOCK_COUNT = 1'b0;

    // one queued transaction from front to back
    typedef struct packed {
        logic             cmd;
        logic [BLK_W-1:0] blk;
    } bba_cmd_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_READ,
        S_EVAL,
        S_BITSCAN,
        S_WRITE
    } bba_state_t;
endpackage
`default_nettype wire

/* design/bitmap_block_allocator.sv */
// bitmap_block_allocator: top level, configuration register and wiring
// depends on bba_pkg, bba_front, bba_back
//
// channel   | signals                          | transfer
// command   | start, busy, command, block_index| start && !busy
// result    | done, status, granted_block      | done, one cycle
// config    | psel penable pwrite paddr pwdata | psel&penable&pwrite
//
// free passes through the read and evaluate states, allocate through read, bit scan and
// evaluate, with the bitmap memory read then written in the back-end sequencer;
// out-of-range, and no-space when every word is full, finish from idle. A two-entry
// queue decouples accepts from execution; busy rises when full. Reset clears the
// full-word summary and written marks; no clearing pass. Results cannot be stalled.
`default_nettype none
module bitmap_block_allocator #(
    parameter int MAX_BLOCKS = bba_pkg::MAX_BLOCKS_DEF,
    parameter int WORD_BITS  = bba_pkg::WORD_BITS_DEF
) (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       start,
    output logic                            busy,
    input  wire logic                       command,
    input  wire logic [bba_pkg::BLK_W-1:0]  block_index,
    output logic                            done,
    output logic [bba_pkg::ST_W-1:0]        status,
    output logic [bba_pkg::BLK_W-1:0]       granted_block,
    input  wire logic                       psel,
    input  wire logic                       penable,
    input  wire logic                       pwrite,
    input  wire logic [1:0]                 paddr,
    input  wire logic [31:0]                pwdata,
    output logic [31:0]                     prdata,
    output logic                            pready
);
    logic [bba_pkg::CFG_W-1:0] bc_reg;
    logic                      q_valid, q_pop;
    bba_pkg::bba_cmd_t         q_data;

    assign pready = 1'b1;
    assign prdata = (paddr[1] == bba_pkg::REG_BLOCK_COUNT) ? {19'd0, bc_reg} : 32'd0;

    // configuration register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bc_reg <= bba_pkg::CFG_W'(4096);
        end
        else if (psel && penable && pwrite && paddr[1] == bba_pkg::REG_BLOCK_COUNT)
        begin
            bc_reg <= pwdata[bba_pkg::CFG_W-1:0];
        end
    end

    bba_front u_front (
        .clk(clk), .rst_n(rst_n), .start(start), .command(command),
        .block_index(block_index), .busy(busy), .q_valid(q_valid),
        .q_data(q_data), .q_pop(q_pop)
    );

    bba_back #(.MAX_BLOCKS(MAX_BLOCKS), .WORD_BITS(WORD_BITS)) u_back (
        .clk(clk), .rst_n(rst_n), .block_count(bc_reg), .q_valid(q_valid),
        .q_data(q_data), .q_pop(q_pop), .done(done), .status(status),
        .granted_block(granted_block)
    );
endmodule
`default_nettype wire

/* design/bba_front.sv */
// bba_front: accepts commands and holds them in a two-entry queue
// depends on bba_pkg
`default_nettype none
module bba_front (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    input  wire logic              command,
    input  wire logic [bba_pkg::BLK_W-1:0] block_index,
    output logic                   busy,
    output logic                   q_valid,
    output bba_pkg::bba_cmd_t      q_data,
    input  wire logic              q_pop
);
    bba_pkg::bba_cmd_t mem_reg [2];
    logic       wp_reg, rp_reg;
    logic [1:0] cnt_reg;
    logic       push;

    assign busy    = cnt_reg[1];
    assign push    = start && !busy;
    assign q_valid = cnt_reg != 2'd0;
    assign q_data  = mem_reg[rp_reg];

    // queue storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wp_reg] <= '{cmd: command, blk: block_index};
        end
    end

    // queue pointers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wp_reg <= ~wp_reg;
            end
            if (q_pop)
            begin
                rp_reg <= ~rp_reg;
            end
            cnt_reg <= cnt_reg + {1'b0, push} - {1'b0, q_pop};
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n) q_pop |-> q_valid)
        else $error("pop from empty queue");
    assert property (@(posedge clk) disable iff (!rst_n) cnt_reg != 2'd3)
        else $error("queue overflow");
    assert property (@(posedge clk) disable iff (!rst_n)
        (push && !q_pop) |=> (cnt_reg == $past(cnt_reg) + 2'd1))
        else $error("queue count lost a push");
endmodule
`default_nettype wire

/* design/bba_back.sv */
// bba_back: bitmap memory, full-word summary and command execution
// depends on bba_pkg
`default_nettype none
module bba_back #(
    parameter int MAX_BLOCKS = bba_pkg::MAX_BLOCKS_DEF,
    parameter int WORD_BITS  = bba_pkg::WORD_BITS_DEF
) (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic [bba_pkg::CFG_W-1:0] block_count,
    input  wire logic                      q_valid,
    input  wire bba_pkg::bba_cmd_t         q_data,
    output logic                           q_pop,
    output logic                           done,
    output logic [bba_pkg::ST_W-1:0]       status,
    output logic [bba_pkg::BLK_W-1:0]      granted_block
);
    localparam int WORDS = (MAX_BLOCKS + WORD_BITS - 1) / WORD_BITS;
    localparam int WA_W  = (WORDS > 1) ? $clog2(WORDS) : 1;
    localparam int BB_W  = $clog2(WORD_BITS);
    localparam int BC_W  = 17;

    bba_pkg::bba_state_t state_reg, state_next;

    logic [WORD_BITS-1:0] mem [WORDS];
    logic [WORD_BITS-1:0] rdata_reg;
    logic [WORDS-1:0]     full_reg;   // word has every bit set
    logic [WORDS-1:0]     wvalid_reg; // word written since reset
    logic                 cmd_reg, cmd_next;
    logic [WA_W-1:0]      wa_reg, wa_next;
    logic [BB_W-1:0]      bit_reg, bit_next;
    logic [BC_W-1:0]      limit_reg, limit_next;
    logic [WORD_BITS-1:0] wdata;
    logic                 we, re, found;
    logic [WA_W-1:0]      fw;
    logic [WORD_BITS-1:0] word, wmask;
    logic [BB_W-1:0]      fb;
    logic                 fb_ok;
    logic [BC_W-1:0]      idx;
    logic [BC_W-1:0]      eff;
    logic                 st_set;
    logic [bba_pkg::ST_W-1:0] st_val;
    logic [bba_pkg::BLK_W-1:0] gr_val;
    logic [bba_pkg::ST_W-1:0] st_reg;
    logic [bba_pkg::BLK_W-1:0] gr_reg;
    logic                 done_reg;

    // effective count saturated to capacity
    assign eff = ({4'd0, block_count} > BC_W'(MAX_BLOCKS)) ? BC_W'(MAX_BLOCKS)
                                                           : {4'd0, block_count};

    // lowest word not full
    always_comb
    begin
        found = 1'b0;
        fw    = '0;
        for (int i = WORDS - 1; i >= 0; i--)
        begin
            if (!full_reg[i])
            begin
                found = 1'b1;
                fw    = WA_W'(i);
            end
        end
    end

    // lowest clear bit of the read word
    assign word = wvalid_reg[wa_reg] ? rdata_reg : '0;
    always_comb
    begin
        fb_ok = 1'b0;
        fb    = '0;
        for (int i = WORD_BITS - 1; i >= 0; i--)
        begin
            if (!word[i])
            begin
                fb_ok = 1'b1;
                fb    = BB_W'(i);
            end
        end
    end

    assign idx   = BC_W'(wa_reg) * BC_W'(WORD_BITS) + BC_W'(bit_reg);
    assign wmask = WORD_BITS'(1) << bit_reg;

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        cmd_next   = cmd_reg;
        wa_next    = wa_reg;
        bit_next   = bit_reg;
        limit_next = limit_reg;
        q_pop      = 1'b0;
        re         = 1'b0;
        we         = 1'b0;
        wdata      = word | wmask;
        st_set     = 1'b0;
        st_val     = bba_pkg::ST_OK;
        gr_val     = '0;
        unique case (state_reg)
            bba_pkg::S_IDLE:
            begin
                if (q_valid)
                begin
                    q_pop      = 1'b1;
                    cmd_next   = q_data.cmd;
                    limit_next = eff;
                    if (q_data.cmd == bba_pkg::CMD_FREE)
                    begin
                        wa_next  = WA_W'({5'd0, q_data.blk} / BC_W'(WORD_BITS));
                        bit_next = BB_W'({5'd0, q_data.blk} % BC_W'(WORD_BITS));
                        if ({5'd0, q_data.blk} >= eff)
                        begin
                            st_set = 1'b1;
                            st_val = bba_pkg::ST_OUT_OF_RANGE;
                        end
                        else
                        begin
                            state_next = bba_pkg::S_READ;
                        end
                    end
                    else if (!found || (BC_W'(fw) * BC_W'(WORD_BITS) >= eff))
                    begin
                        st_set = 1'b1;
                        st_val = bba_pkg::ST_NO_SPACE;
                    end
                    else
                    begin
                        wa_next    = fw;
                        state_next = bba_pkg::S_READ;
                    end
                end
            end
            bba_pkg::S_READ:
            begin
                re         = 1'b1;
                state_next = (cmd_reg == bba_pkg::CMD_FREE) ? bba_pkg::S_EVAL
                                                            : bba_pkg::S_BITSCAN;
            end
            bba_pkg::S_BITSCAN:
            begin
                bit_next   = fb;
                state_next = fb_ok ? bba_pkg::S_EVAL : bba_pkg::S_IDLE;
                if (!fb_ok)
                begin
                    st_set = 1'b1;
                    st_val = bba_pkg::ST_NO_SPACE;
                end
            end
            bba_pkg::S_EVAL:
            begin
                state_next = bba_pkg::S_IDLE;
                st_set     = 1'b1;
                if (cmd_reg == bba_pkg::CMD_FREE)
                begin
                    if (!word[bit_reg])
                    begin
                        st_val = bba_pkg::ST_ALREADY_FREE;
                    end
                    else
                    begin
                        we    = 1'b1;
                        wdata = word & ~wmask;
                    end
                end
                else if (idx >= limit_reg)
                begin
                    st_val = bba_pkg::ST_NO_SPACE;
                end
                else
                begin
                    we     = 1'b1;
                    gr_val = bba_pkg::BLK_W'(idx);
                end
            end
            default:
            begin
                state_next = bba_pkg::S_IDLE;
            end
        endcase
    end

    // bitmap memory
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[wa_reg] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[wa_reg];
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        cmd_reg   <= cmd_next;
        wa_reg    <= wa_next;
        bit_reg   <= bit_next;
        limit_reg <= limit_next;
        if (st_set)
        begin
            st_reg <= st_val;
            gr_reg <= gr_val;
        end
    end

    // control and summary state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= bba_pkg::S_IDLE;
            full_reg   <= '0;
            wvalid_reg <= '0;
            done_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= st_set;
            if (we)
            begin
                full_reg[wa_reg]   <= &wdata;
                wvalid_reg[wa_reg] <= 1'b1;
            end
        end
    end

    assign done          = done_reg;
    assign status        = st_reg;
    assign granted_block = gr_reg;

    assert property (@(posedge clk) disable iff (!rst_n)
        we |-> (state_reg == bba_pkg::S_EVAL))
        else $error("bitmap write outside evaluate");
    assert property (@(posedge clk) disable iff (!rst_n)
        (done && status != bba_pkg::ST_OK) |-> granted_block == '0)
        else $error("grant on failure");
    assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> (state_reg == bba_pkg::S_IDLE))
        else $error("pop while busy");
    assert property (@(posedge clk) disable iff (!rst_n)
        (we && cmd_reg == bba_pkg::CMD_ALLOC) |-> !word[bit_reg])
        else $error("allocated a used block");
endmodule
`default_nettype wire
